// ===== rtl/mrse_pkg.sv =====
// Shared types, constants and the CRC step of the Modbus RTU slave engine.
package mrse_pkg;

  localparam int FRAME_MAX_DEF     = 64;
  localparam int HOLDING_COUNT_DEF = 64;
  localparam int INPUT_COUNT_DEF   = 64;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] FC_RD_HOLD  = 8'h03;
  localparam logic [7:0] FC_RD_INP   = 8'h04;
  localparam logic [7:0] FC_WR_ONE   = 8'h06;
  localparam logic [7:0] FC_WR_MULTI = 8'h10;
  localparam logic [7:0] EXC_FLAG    = 8'h80;

  localparam logic [7:0] EXC_FUNC = 8'h01;
  localparam logic [7:0] EXC_ADDR = 8'h02;
  localparam logic [7:0] EXC_DATA = 8'h03;

  localparam logic [2:0] KIND_RX       = 3'd0;
  localparam logic [2:0] KIND_SET_INP  = 3'd1;
  localparam logic [2:0] KIND_SET_HOLD = 3'd2;
  localparam logic [2:0] KIND_GET_HOLD = 3'd3;
  localparam logic [2:0] KIND_TAKE_EVT = 3'd4;

  localparam logic [2:0] REG_SLAVE_ADDR   = 3'd0;
  localparam logic [2:0] REG_HOLDING_BASE = 3'd4;

  // table port request; sel high picks the input table
  typedef struct packed {
    logic        we;
    logic        wsel;
    logic [7:0]  waddr;
    logic [15:0] wdata;
    logic        re;
    logic        rsel;
    logic [7:0]  raddr;
  } tbl_req_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] x;
    x = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction

endpackage

// ===== rtl/mrse_tables.sv =====
// Holding and input register tables: one write and one registered read a cycle.
module mrse_tables #(
  parameter int HOLDING_COUNT = mrse_pkg::HOLDING_COUNT_DEF,
  parameter int INPUT_COUNT   = mrse_pkg::INPUT_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mrse_pkg::tbl_req_t req,
  output logic [15:0]        rdata
);
  import mrse_pkg::*;

  localparam int HAW = (HOLDING_COUNT > 1) ? $clog2(HOLDING_COUNT) : 1;
  localparam int IAW = (INPUT_COUNT > 1) ? $clog2(INPUT_COUNT) : 1;

  logic [15:0] hold_mem [HOLDING_COUNT];
  logic [15:0] inp_mem  [INPUT_COUNT];
  logic [HOLDING_COUNT-1:0] hold_vld_r;
  logic [INPUT_COUNT-1:0]   inp_vld_r;
  logic [15:0] hold_q_r, inp_q_r;
  logic        rsel_r, rvld_r;

  always_ff @(posedge clk) begin
    if (req.we && !req.wsel) hold_mem[req.waddr[HAW-1:0]] <= req.wdata;
    if (req.we && req.wsel)  inp_mem[req.waddr[IAW-1:0]]  <= req.wdata;
    if (req.re) begin
      hold_q_r <= hold_mem[req.raddr[HAW-1:0]];
      inp_q_r  <= inp_mem[req.raddr[IAW-1:0]];
      rsel_r   <= req.rsel;
    end
  end

  // valid bits stand for the clear at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= '0;
      inp_vld_r  <= '0;
      rvld_r     <= 1'b0;
    end else begin
      if (req.re) begin
        rvld_r <= req.rsel ? inp_vld_r[req.raddr[IAW-1:0]] : hold_vld_r[req.raddr[HAW-1:0]];
      end
      if (req.we && !req.wsel) hold_vld_r[req.waddr[HAW-1:0]] <= 1'b1;
      if (req.we && req.wsel)  inp_vld_r[req.waddr[IAW-1:0]]  <= 1'b1;
    end
  end

  assign rdata = rvld_r ? (rsel_r ? inp_q_r : hold_q_r) : 16'h0000;

endmodule

// ===== rtl/modbus_rtu_slave_engine_unit.sv =====
// Top level of the Modbus RTU slave engine: frame intake, checks and response sequencer.
//
// Input stream (in_*): one beat per item. in_tuser holds the kind. Kind 0 beats carry a
// request byte, in_tlast marks the frame's last byte. Kinds 1..4 are application accesses
// (set input reg, set holding reg, read holding reg, take the write event).
// Output stream (out_*): out_tuser is 0 for a response byte (out_tlast on the last byte
// of the frame, CRC low byte before high) and 1 for an application answer.
// Request bytes are taken while idle. At the end mark the frame is checked in S_CHK,
// then the response bytes go out in order as the receiver takes them; a read steps
// S_RDA (table read), S_RDH (high byte), S_RDL (low byte) per register over the single
// table read port. A write-multiple request copies frame buffer to table through S_WA,
// S_WB and S_WC per register before its reply. Application accesses answer from S_APP.
// in_tready is high only while no frame or answer is being worked on.
// A stalled receiver holds the output register; the sequencer waits on it.
// Reset (synchronous, rst_n low) clears both tables, the frame state, the write event
// and restores own bus address 1 and holding base 256. The user must write the APB port
// (cfg_*) only while idle; the block does not enforce this.
module modbus_rtu_slave_engine_unit #(
  parameter int FRAME_MAX     = mrse_pkg::FRAME_MAX_DEF,
  parameter int HOLDING_COUNT = mrse_pkg::HOLDING_COUNT_DEF,
  parameter int INPUT_COUNT   = mrse_pkg::INPUT_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // rx_byte[7:0], reg_offset[15:8], reg_value[31:16]
  input  logic        in_tlast,   // frame_end
  input  logic [2:0]  in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // tx_byte[7:0], app_ok[8], app_value[24:9],
                                  // event_offset[32:25], event_count[39:33]
  output logic        out_tlast,  // tx_last
  output logic        out_tuser,  // result_kind
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import mrse_pkg::*;

  localparam int FAW = $clog2(FRAME_MAX);
  localparam int LW  = $clog2(FRAME_MAX + 1);
  localparam int QW  = $clog2(FRAME_MAX / 2 + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CHK  = 4'd1;
  localparam logic [3:0] S_HDR  = 4'd2;
  localparam logic [3:0] S_RDA  = 4'd3;
  localparam logic [3:0] S_RDH  = 4'd4;
  localparam logic [3:0] S_RDL  = 4'd5;
  localparam logic [3:0] S_CRCL = 4'd6;
  localparam logic [3:0] S_CRCH = 4'd7;
  localparam logic [3:0] S_WA   = 4'd8;
  localparam logic [3:0] S_WB   = 4'd9;
  localparam logic [3:0] S_WC   = 4'd10;
  localparam logic [3:0] S_APP  = 4'd11;

  localparam logic [1:0] M_CRC  = 2'd0;  // header then CRC
  localparam logic [1:0] M_READ = 2'd1;  // header, register data, CRC
  localparam logic [1:0] M_ECHO = 2'd2;  // header is the whole reply

  // state
  logic [3:0]    state_r;
  logic [LW-1:0] len_r;
  logic          ovf_r;
  logic [15:0]   rxcrc_r, txcrc_r;
  logic [7:0]    q_r    [8];
  logic [7:0]    resp_r [8];
  logic [3:0]    hdr_len_r;
  logic [1:0]    mode_r;
  logic          rd_inp_r;
  logic [7:0]    off_r;
  logic [QW-1:0] qty_r, idx_r;
  logic [7:0]    hi_r;
  logic          evt_pend_r;
  logic [7:0]    evt_off_r;
  logic [6:0]    evt_cnt_r;
  logic [2:0]    ap_kind_r;
  logic          ap_ok_r;
  logic [7:0]    ap_evo_r;
  logic [6:0]    ap_evc_r;

  // input fields
  logic [7:0]  rx_byte, reg_offset;
  logic [15:0] reg_value;
  assign rx_byte    = in_tdata[7:0];
  assign reg_offset = in_tdata[15:8];
  assign reg_value  = in_tdata[31:16];

  logic in_acc;
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // configuration
  logic [7:0]  slave_addr_r;
  logic [15:0] hold_base_r;
  logic        cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = cfg_paddr[2] ? {16'h0000, hold_base_r} : {24'h000000, slave_addr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_addr_r <= 8'd1;
      hold_base_r  <= 16'd256;
    end else if (cfg_wr) begin
      if (cfg_paddr[2]) hold_base_r <= cfg_pwdata[15:0];
      else              slave_addr_r <= cfg_pwdata[7:0];
    end
  end

  // frame buffer, undefined until written
  logic [7:0]     fb_mem [FRAME_MAX];
  logic [7:0]     fb_q_r;
  logic           fb_re;
  logic [6:0]     fb_ridx;
  logic           fb_we;
  assign fb_we = in_acc && (in_tuser == KIND_RX) && (7'(len_r) < 7'(FRAME_MAX));

  always_ff @(posedge clk) begin
    if (fb_we) fb_mem[len_r[FAW-1:0]] <= rx_byte;
    if (fb_re) fb_q_r <= fb_mem[fb_ridx[FAW-1:0]];
  end

  // register tables
  tbl_req_t    treq;
  logic [15:0] trdata;

  mrse_tables #(
    .HOLDING_COUNT(HOLDING_COUNT),
    .INPUT_COUNT  (INPUT_COUNT)
  ) u_tables (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (treq),
    .rdata(trdata)
  );

  // frame checks, from the captured header, frame length, CRC and overflow flag
  logic [7:0]  fc;
  logic [15:0] addr, qty;
  logic [16:0] off17, rd_off17, rd_cnt17;
  logic        below, rd_bad, wr_bad, w16_bad3, w16_bad2, drop, fixlen;
  assign fc    = q_r[1];
  assign addr  = {q_r[2], q_r[3]};
  assign qty   = {q_r[4], q_r[5]};
  assign below = addr < hold_base_r;
  assign off17 = {1'b0, addr} - {1'b0, hold_base_r};
  assign rd_off17 = (fc == FC_RD_INP) ? {1'b0, addr} : off17;
  assign rd_cnt17 = (fc == FC_RD_INP) ? 17'(INPUT_COUNT) : 17'(HOLDING_COUNT);
  assign rd_bad = ((fc == FC_RD_HOLD) && below) || (rd_off17 >= rd_cnt17)
                || ({1'b0, qty} > (rd_cnt17 - rd_off17))
                || ((18'd5 + {1'b0, qty, 1'b0}) > 18'(FRAME_MAX));
  assign wr_bad = below || (off17 >= 17'(HOLDING_COUNT));
  assign w16_bad3 = (10'(len_r) < 10'd9) || (qty == 16'd0)
                  || ({9'd0, q_r[6]} != {qty, 1'b0})
                  || (10'(len_r) != (10'd9 + {2'b00, q_r[6]}));
  assign w16_bad2 = wr_bad || ({1'b0, qty} > (17'(HOLDING_COUNT) - off17));
  assign drop = ovf_r || (10'(len_r) < 10'd4) || (rxcrc_r != 16'h0000)
              || (q_r[0] != slave_addr_r);
  assign fixlen = (fc == FC_RD_HOLD) || (fc == FC_RD_INP) || (fc == FC_WR_ONE);

  function automatic logic fixlen_bad();
    return fixlen && (10'(len_r) != 10'd8);
  endfunction

  // outcome of the checks: next state, reply header and write event
  logic [3:0] chk_state, chk_hdr;
  logic [1:0] chk_mode;
  logic [7:0] chk_off, chk_code;
  logic       chk_exc, chk_evt;
  logic [7:0] chk_resp [8];

  always_comb begin
    chk_state = S_HDR;
    chk_mode  = M_CRC;
    chk_hdr   = 4'd3;
    chk_off   = rd_off17[7:0];
    chk_code  = EXC_FUNC;
    chk_exc   = 1'b1;
    chk_evt   = 1'b0;
    for (int k = 0; k < 8; k++) chk_resp[k] = q_r[k];
    if (drop) begin
      chk_state = S_IDLE;
    end else if (fixlen_bad()) begin
      chk_code = EXC_DATA;
    end else if ((fc == FC_RD_HOLD) || (fc == FC_RD_INP)) begin
      if (qty == 16'd0) begin
        chk_code = EXC_DATA;
      end else if (rd_bad) begin
        chk_code = EXC_ADDR;
      end else begin
        chk_exc     = 1'b0;
        chk_mode    = M_READ;
        chk_resp[2] = {qty[6:0], 1'b0};
      end
    end else if (fc == FC_WR_ONE) begin
      if (wr_bad) begin
        chk_code = EXC_ADDR;
      end else begin
        chk_exc  = 1'b0;
        chk_hdr  = 4'd8;
        chk_mode = M_ECHO;
        chk_evt  = 1'b1;
      end
    end else if (fc == FC_WR_MULTI) begin
      if (w16_bad3) begin
        chk_code = EXC_DATA;
      end else if (w16_bad2) begin
        chk_code = EXC_ADDR;
      end else begin
        chk_exc   = 1'b0;
        chk_hdr   = 4'd6;
        chk_off   = off17[7:0];
        chk_evt   = 1'b1;
        chk_state = S_WA;
      end
    end
    if (chk_exc) begin
      chk_resp[1] = fc | EXC_FLAG;
      chk_resp[2] = chk_code;
    end
    chk_resp[0] = slave_addr_r;
  end

  // emission into the output register
  logic        slot, emit, e_kind, e_last, e_ok, upd_crc;
  logic [7:0]  e_byte, e_evo;
  logic [15:0] e_val;
  logic [6:0]  e_evc;
  assign slot = !out_tvalid || out_tready;

  always_comb begin
    emit    = 1'b0;
    e_kind  = 1'b0;
    e_byte  = 8'h00;
    e_last  = 1'b0;
    e_ok    = 1'b0;
    e_val   = 16'h0000;
    e_evo   = 8'h00;
    e_evc   = 7'd0;
    upd_crc = 1'b0;
    unique case (state_r)
      S_HDR: begin
        emit    = slot;
        upd_crc = 1'b1;
        e_byte  = resp_r[idx_r[2:0]];
        e_last  = (mode_r == M_ECHO) && (4'(idx_r) == hdr_len_r - 4'd1);
      end
      S_RDH: begin
        emit    = slot;
        upd_crc = 1'b1;
        e_byte  = trdata[15:8];
      end
      S_RDL: begin
        emit    = slot;
        upd_crc = 1'b1;
        e_byte  = trdata[7:0];
      end
      S_CRCL: begin
        emit   = slot;
        e_byte = txcrc_r[7:0];
      end
      S_CRCH: begin
        emit   = slot;
        e_byte = txcrc_r[15:8];
        e_last = 1'b1;
      end
      S_APP: begin
        emit   = slot;
        e_kind = 1'b1;
        e_ok   = ap_ok_r;
        e_val  = ((ap_kind_r == KIND_GET_HOLD) && ap_ok_r) ? trdata : 16'h0000;
        e_evo  = ap_evo_r;
        e_evc  = ap_evc_r;
      end
      default: ;
    endcase
  end

  logic        out_valid_r, out_last_r, out_kind_r;
  logic [39:0] out_data_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_kind_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (emit) begin
      out_data_r <= {e_evc, e_evo, e_val, e_ok, e_byte};
      out_last_r <= e_last;
      out_kind_r <= e_kind;
    end
  end

  // table and buffer port drive
  always_comb begin
    treq    = '0;
    fb_re   = 1'b0;
    fb_ridx = 7'd0;
    if (in_acc && (in_tuser == KIND_SET_INP) && (9'(reg_offset) < 9'(INPUT_COUNT))) begin
      treq.we    = 1'b1;
      treq.wsel  = 1'b1;
      treq.waddr = reg_offset;
      treq.wdata = reg_value;
    end
    if (in_acc && (in_tuser == KIND_SET_HOLD) && (9'(reg_offset) < 9'(HOLDING_COUNT))) begin
      treq.we    = 1'b1;
      treq.waddr = reg_offset;
      treq.wdata = reg_value;
    end
    if (in_acc && (in_tuser == KIND_GET_HOLD)) begin
      treq.re    = 1'b1;
      treq.raddr = reg_offset;
    end
    if ((state_r == S_CHK) && !drop && (fc == FC_WR_ONE) && !fixlen_bad() && !wr_bad) begin
      treq.we    = 1'b1;
      treq.waddr = off17[7:0];
      treq.wdata = qty;
    end
    if (state_r == S_RDA) begin
      treq.re    = 1'b1;
      treq.rsel  = rd_inp_r;
      treq.raddr = 8'(off_r + 8'(idx_r));
    end
    if (state_r == S_WA) begin
      fb_re   = 1'b1;
      fb_ridx = 7'd7 + {idx_r, 1'b0};
    end
    if (state_r == S_WB) begin
      fb_re   = 1'b1;
      fb_ridx = 7'd8 + {idx_r, 1'b0};
    end
    if (state_r == S_WC) begin
      treq.we    = 1'b1;
      treq.waddr = 8'(off_r + 8'(idx_r));
      treq.wdata = {hi_r, fb_q_r};
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      len_r      <= '0;
      ovf_r      <= 1'b0;
      rxcrc_r    <= CRC_INIT;
      evt_pend_r <= 1'b0;
      evt_off_r  <= 8'd0;
      evt_cnt_r  <= 7'd0;
      idx_r      <= '0;
    end else begin
      if (emit && upd_crc) txcrc_r <= crc_byte(txcrc_r, e_byte);
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            ap_kind_r <= in_tuser;
            ap_evo_r  <= ((in_tuser == KIND_TAKE_EVT) && evt_pend_r) ? evt_off_r : 8'd0;
            ap_evc_r  <= ((in_tuser == KIND_TAKE_EVT) && evt_pend_r) ? evt_cnt_r : 7'd0;
            case (in_tuser) inside
              KIND_RX: begin
                if (fb_we) begin
                  len_r   <= len_r + LW'(1);
                  rxcrc_r <= crc_byte(rxcrc_r, rx_byte);
                  if (7'(len_r) < 7'd8) q_r[len_r[2:0]] <= rx_byte;
                end else begin
                  ovf_r <= 1'b1;
                end
                if (in_tlast) state_r <= S_CHK;
              end
              KIND_SET_INP: begin
                ap_ok_r <= 9'(reg_offset) < 9'(INPUT_COUNT);
                state_r <= S_APP;
              end
              KIND_SET_HOLD, KIND_GET_HOLD: begin
                ap_ok_r <= 9'(reg_offset) < 9'(HOLDING_COUNT);
                state_r <= S_APP;
              end
              KIND_TAKE_EVT: begin
                ap_ok_r    <= evt_pend_r;
                evt_pend_r <= 1'b0;
                state_r    <= S_APP;
              end
              default: ;
            endcase
          end
        end
        S_CHK: begin
          len_r     <= '0;
          ovf_r     <= 1'b0;
          rxcrc_r   <= CRC_INIT;
          txcrc_r   <= CRC_INIT;
          idx_r     <= '0;
          mode_r    <= chk_mode;
          hdr_len_r <= chk_hdr;
          rd_inp_r  <= (fc == FC_RD_INP);
          off_r     <= chk_off;
          qty_r     <= qty[QW-1:0];
          state_r   <= chk_state;
          for (int k = 0; k < 8; k++) resp_r[k] <= chk_resp[k];
          if (chk_evt) begin
            evt_pend_r <= 1'b1;
            evt_off_r  <= off17[7:0];
            evt_cnt_r  <= (fc == FC_WR_ONE) ? 7'd1 : qty[6:0];
          end
        end
        S_HDR: begin
          if (slot) begin
            if (4'(idx_r) == hdr_len_r - 4'd1) begin
              idx_r <= '0;
              if (mode_r == M_ECHO)      state_r <= S_IDLE;
              else if (mode_r == M_READ) state_r <= S_RDA;
              else                       state_r <= S_CRCL;
            end else begin
              idx_r <= idx_r + QW'(1);
            end
          end
        end
        S_RDA: state_r <= S_RDH;
        S_RDH: if (slot) state_r <= S_RDL;
        S_RDL: begin
          if (slot) begin
            if (idx_r == qty_r - QW'(1)) begin
              state_r <= S_CRCL;
            end else begin
              idx_r   <= idx_r + QW'(1);
              state_r <= S_RDA;
            end
          end
        end
        S_CRCL: if (slot) state_r <= S_CRCH;
        S_CRCH: if (slot) state_r <= S_IDLE;
        S_WA: state_r <= S_WB;
        S_WB: begin
          hi_r    <= fb_q_r;
          state_r <= S_WC;
        end
        S_WC: begin
          if (idx_r == qty_r - QW'(1)) begin
            idx_r   <= '0;
            state_r <= S_HDR;
          end else begin
            idx_r   <= idx_r + QW'(1);
            state_r <= S_WA;
          end
        end
        S_APP: if (slot) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
